[rtl/core/tbw_pkg.sv]
`default_nettype none
package tbw_pkg;

   localparam int WEIGHT_WIDTH = 24;
   localparam int QUOT_BITS = WEIGHT_WIDTH + 1;
   localparam int NUM_DOTS = 5;
   localparam int NUM_CROSS = 6;
   localparam int NUM_LANES = 2;

   // Edge vector groups: 0 is A - C, 1 is B - C, 2 is P - C.
   // Dot products in order d00, d01, d11, d20, d21.
   localparam int DOT_L [NUM_DOTS] = '{0, 0, 1, 2, 2};
   localparam int DOT_R [NUM_DOTS] = '{0, 1, 1, 0, 1};

   // Products of dot products: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20.
   localparam int CROSS_L [NUM_CROSS] = '{0, 1, 2, 1, 0, 1};
   localparam int CROSS_R [NUM_CROSS] = '{2, 1, 3, 4, 4, 3};

endpackage
`default_nettype wire

[rtl/core/tbw_if.sv]
`default_nettype none
interface tbw_req_if #(parameter int COORD_WIDTH = 24);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] src_x;
   logic signed [COORD_WIDTH-1:0] src_y;
   logic signed [COORD_WIDTH-1:0] src_z;
   logic signed [COORD_WIDTH-1:0] corner_a_x;
   logic signed [COORD_WIDTH-1:0] corner_a_y;
   logic signed [COORD_WIDTH-1:0] corner_a_z;
   logic signed [COORD_WIDTH-1:0] corner_b_x;
   logic signed [COORD_WIDTH-1:0] corner_b_y;
   logic signed [COORD_WIDTH-1:0] corner_b_z;
   logic signed [COORD_WIDTH-1:0] corner_c_x;
   logic signed [COORD_WIDTH-1:0] corner_c_y;
   logic signed [COORD_WIDTH-1:0] corner_c_z;

   modport source (
      output valid, src_x, src_y, src_z, corner_a_x, corner_a_y, corner_a_z,
             corner_b_x, corner_b_y, corner_b_z, corner_c_x, corner_c_y, corner_c_z,
      input  ready
   );
   modport sink (
      input  valid, src_x, src_y, src_z, corner_a_x, corner_a_y, corner_a_z,
             corner_b_x, corner_b_y, corner_b_z, corner_c_x, corner_c_y, corner_c_z,
      output ready
   );
endinterface

interface tbw_rsp_if import tbw_pkg::*;;
   logic                           valid;
   logic                           ready;
   logic signed [WEIGHT_WIDTH-1:0] weight_a;
   logic signed [WEIGHT_WIDTH-1:0] weight_b;
   logic signed [WEIGHT_WIDTH-1:0] weight_c;
   logic                           degenerate;
   logic                           saturated;

   modport source (
      output valid, weight_a, weight_b, weight_c, degenerate, saturated,
      input  ready
   );
   modport sink (
      input  valid, weight_a, weight_b, weight_c, degenerate, saturated,
      output ready
   );
endinterface
`default_nettype wire

[rtl/core/tbw_dot.sv]
`default_nettype none
module tbw_dot import tbw_pkg::*; #(
   parameter int CW = 24,
   localparam int SW = 2 * CW + 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic signed [CW-1:0] pt [3],
   input  wire logic signed [CW-1:0] ca [3],
   input  wire logic signed [CW-1:0] cb [3],
   input  wire logic signed [CW-1:0] cc [3],
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic signed [SW-1:0]      dot [NUM_DOTS]
);

   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int NS = 3;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   en;

   logic signed [DW-1:0] e_in [3][3];
   logic signed [DW-1:0] e_ff [3][3];
   logic signed [PW-1:0] prod_in [NUM_DOTS][3];
   logic signed [PW-1:0] prod_ff [NUM_DOTS][3];
   logic signed [SW-1:0] dot_in [NUM_DOTS];
   logic signed [SW-1:0] dot_ff [NUM_DOTS];

   assign en[NS] = out_ready;
   for (genvar k = 0; k < NS; k++) begin : g_en
      assign en[k] = ~vld_ff[k] | en[k+1];
   end
   assign in_ready  = en[0];
   assign out_valid = vld_ff[NS-1];
   assign dot       = dot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         if (en[1]) vld_ff[1] <= vld_ff[0];
         if (en[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_in[0][i] = DW'(ca[i]) - DW'(cc[i]);
         e_in[1][i] = DW'(cb[i]) - DW'(cc[i]);
         e_in[2][i] = DW'(pt[i]) - DW'(cc[i]);
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_DOTS; k++) begin
         for (int i = 0; i < 3; i++) begin
            prod_in[k][i] = e_ff[DOT_L[k]][i] * e_ff[DOT_R[k]][i];
         end
         dot_in[k] = SW'(prod_ff[k][0]) + SW'(prod_ff[k][1]) + SW'(prod_ff[k][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) e_ff <= e_in;
      if (en[1]) prod_ff <= prod_in;
      if (en[2]) dot_ff <= dot_in;
   end

endmodule
`default_nettype wire

[rtl/core/tbw_cross.sv]
`default_nettype none
module tbw_cross import tbw_pkg::*; #(
   parameter int CW = 24,
   localparam int SW = 2 * CW + 4,
   localparam int NW = 2 * SW + 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic signed [SW-1:0] dot [NUM_DOTS],
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic signed [NW-1:0]      den,
   output logic signed [NW-1:0]      nu,
   output logic signed [NW-1:0]      nv
);

   localparam int BW = 2 * SW;
   localparam int H  = (SW + 1) / 2;
   localparam int HW = SW - H;
   localparam int NS = 3;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   en;

   logic signed [H:0]    lo_s [NUM_DOTS];
   logic signed [HW-1:0] hi_s [NUM_DOTS];

   logic signed [2*H+1:0]  ll_in [NUM_CROSS];
   logic signed [2*H+1:0]  ll_ff [NUM_CROSS];
   logic signed [SW:0]     lh_in [NUM_CROSS];
   logic signed [SW:0]     lh_ff [NUM_CROSS];
   logic signed [SW:0]     hl_in [NUM_CROSS];
   logic signed [SW:0]     hl_ff [NUM_CROSS];
   logic signed [2*HW-1:0] hh_in [NUM_CROSS];
   logic signed [2*HW-1:0] hh_ff [NUM_CROSS];
   logic signed [SW+1:0]   mid [NUM_CROSS];
   logic signed [BW-1:0]   p_in [NUM_CROSS];
   logic signed [BW-1:0]   p_ff [NUM_CROSS];

   logic signed [NW-1:0] den_in, nu_in, nv_in;
   logic signed [NW-1:0] den_ff, nu_ff, nv_ff;

   assign en[NS] = out_ready;
   for (genvar k = 0; k < NS; k++) begin : g_en
      assign en[k] = ~vld_ff[k] | en[k+1];
   end
   assign in_ready  = en[0];
   assign out_valid = vld_ff[NS-1];
   assign den = den_ff;
   assign nu  = nu_ff;
   assign nv  = nv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         if (en[1]) vld_ff[1] <= vld_ff[0];
         if (en[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   // Each dot product operand is split into a signed high half and an unsigned low half.
   always_comb begin
      for (int j = 0; j < NUM_DOTS; j++) begin
         lo_s[j] = $signed({1'b0, dot[j][H-1:0]});
         hi_s[j] = $signed(dot[j][SW-1:H]);
      end
      for (int k = 0; k < NUM_CROSS; k++) begin
         ll_in[k] = lo_s[CROSS_L[k]] * lo_s[CROSS_R[k]];
         lh_in[k] = lo_s[CROSS_L[k]] * hi_s[CROSS_R[k]];
         hl_in[k] = hi_s[CROSS_L[k]] * lo_s[CROSS_R[k]];
         hh_in[k] = hi_s[CROSS_L[k]] * hi_s[CROSS_R[k]];
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_CROSS; k++) begin
         mid[k]  = (SW+2)'(lh_ff[k]) + (SW+2)'(hl_ff[k]);
         p_in[k] = (BW'(hh_ff[k]) <<< (2 * H)) + (BW'(mid[k]) <<< H) + BW'(ll_ff[k]);
      end
      den_in = NW'(p_ff[0]) - NW'(p_ff[1]);
      nu_in  = NW'(p_ff[2]) - NW'(p_ff[3]);
      nv_in  = NW'(p_ff[4]) - NW'(p_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
      end
      if (en[1]) p_ff <= p_in;
      if (en[2]) begin
         den_ff <= den_in;
         nu_ff  <= nu_in;
         nv_ff  <= nv_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/tbw_div.sv]
`default_nettype none
module tbw_div import tbw_pkg::*; #(
   parameter int CW = 24,
   parameter int FRAC = 16,
   localparam int NW = 4 * CW + 9
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic signed [NW-1:0]     den,
   input  wire logic signed [NW-1:0]     nu,
   input  wire logic signed [NW-1:0]     nv,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic signed [WEIGHT_WIDTH-1:0] weight [NUM_LANES],
   output logic [NUM_LANES-1:0]          sat,
   output logic                          deg
);

   localparam int RW = NW + FRAC + 26;
   localparam int QB = QUOT_BITS;
   localparam int NS = QB + 2;
   localparam logic [QB-1:0] LIM_POS = QB'((1 << (WEIGHT_WIDTH - 1)) - 1);
   localparam logic [QB-1:0] LIM_NEG = QB'(1 << (WEIGHT_WIDTH - 1));

   logic [NS-1:0] vld_ff;
   logic [NS:0]   en;

   logic [RW-1:0] r_ff   [QB+1][NUM_LANES];
   logic [QB-1:0] q_ff   [QB+1][NUM_LANES];
   logic          neg_ff [QB+1][NUM_LANES];
   logic [RW-1:0] dv_ff  [QB+1];
   logic          deg_ff [QB+1];

   logic signed [NW-1:0] num [NUM_LANES];
   logic [NW-1:0]        mag [NUM_LANES];
   logic [RW-1:0]        r0_in [NUM_LANES];
   logic                 neg0_in [NUM_LANES];

   logic signed [WEIGHT_WIDTH-1:0] wt_in [NUM_LANES];
   logic signed [WEIGHT_WIDTH-1:0] wt_ff [NUM_LANES];
   logic [NUM_LANES-1:0]           sat_in, sat_ff;
   logic                           dego_ff;

   assign en[NS] = out_ready;
   for (genvar k = 0; k < NS; k++) begin : g_en
      assign en[k] = ~vld_ff[k] | en[k+1];
   end
   assign in_ready  = en[0];
   assign out_valid = vld_ff[NS-1];
   assign weight    = wt_ff;
   assign sat       = sat_ff;
   assign deg       = dego_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // The rounded quotient is (2|n| * 2^FRAC + den) / (2 den).
   always_comb begin
      num[0] = nu;
      num[1] = nv;
      for (int l = 0; l < NUM_LANES; l++) begin
         neg0_in[l] = num[l][NW-1];
         mag[l]     = neg0_in[l] ? NW'(-num[l]) : NW'(num[l]);
         r0_in[l]   = (RW'(mag[l]) << (FRAC + 1)) + RW'($unsigned(den));
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            r_ff[0][l]   <= r0_in[l];
            q_ff[0][l]   <= '0;
            neg_ff[0][l] <= neg0_in[l];
         end
         dv_ff[0]  <= RW'($unsigned(den)) << 1;
         deg_ff[0] <= (den == '0);
      end
   end

   for (genvar s = 1; s <= QB; s++) begin : g_bit
      logic [RW-1:0] trial;
      logic [RW-1:0] r_in [NUM_LANES];
      logic [QB-1:0] q_in [NUM_LANES];

      always_comb begin
         trial = dv_ff[s-1] << (QB - s);
         for (int l = 0; l < NUM_LANES; l++) begin
            r_in[l] = r_ff[s-1][l];
            q_in[l] = q_ff[s-1][l];
            if (r_ff[s-1][l] >= trial) begin
               r_in[l] = r_ff[s-1][l] - trial;
               q_in[l][QB-s] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            r_ff[s]   <= r_in;
            q_ff[s]   <= q_in;
            neg_ff[s] <= neg_ff[s-1];
            dv_ff[s]  <= dv_ff[s-1];
            deg_ff[s] <= deg_ff[s-1];
         end
      end
   end

   always_comb begin
      logic [QB-1:0] lim;
      logic [QB-1:0] qm;
      logic [QB-1:0] val;
      for (int l = 0; l < NUM_LANES; l++) begin
         lim = neg_ff[QB][l] ? LIM_NEG : LIM_POS;
         sat_in[l] = q_ff[QB][l] > lim;
         qm  = sat_in[l] ? lim : q_ff[QB][l];
         val = neg_ff[QB][l] ? QB'(-qm) : qm;
         wt_in[l] = $signed(val[WEIGHT_WIDTH-1:0]);
         if (deg_ff[QB]) begin
            wt_in[l]  = '0;
            sat_in[l] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         wt_ff   <= wt_in;
         sat_ff  <= sat_in;
         dego_ff <= deg_ff[QB];
      end
   end

endmodule
`default_nettype wire

[rtl/core/triangle_barycentric_weights_top.sv]
// Channel   Direction  Payload
// req_ch    in         query point and corners A, B, C, signed Q12.12
// rsp_ch    out        weights of A, B, C in signed Q8.16, degenerate, saturated
//
// One request enters per cycle while no stalled response backs up the pipeline.
// The divider resolves one quotient bit per stage.
// Reset clears only the valid bits of the pipeline stages.
// A stalled response holds each full stage whose later stages are all full; the rest keep filling.
`default_nettype none
module triangle_barycentric_weights_top import tbw_pkg::*; #(
   parameter int COORD_WIDTH = 24,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tbw_req_if.sink    req_ch,
   tbw_rsp_if.source  rsp_ch
);

   localparam int CW = COORD_WIDTH;
   localparam int SW = 2 * CW + 4;
   localparam int NW = 2 * SW + 1;
   localparam int WW = WEIGHT_WIDTH;
   localparam int XW = WW + 3;
   localparam logic signed [XW-1:0] ONE  = XW'(1) << WEIGHT_FRAC_BITS;
   localparam logic signed [XW-1:0] WMAX = XW'((1 << (WW - 1)) - 1);
   localparam logic signed [XW-1:0] WMIN = -(XW'(1) << (WW - 1));

   logic signed [CW-1:0] pt [3];
   logic signed [CW-1:0] ca [3];
   logic signed [CW-1:0] cb [3];
   logic signed [CW-1:0] cc [3];

   logic                 dot_valid, dot_ready;
   logic signed [SW-1:0] dot [NUM_DOTS];
   logic                 crs_valid, crs_ready;
   logic signed [NW-1:0] den, nu, nv;
   logic                 div_valid, div_ready;
   logic signed [WW-1:0] weight [NUM_LANES];
   logic [NUM_LANES-1:0] div_sat;
   logic                 div_deg;

   logic signed [XW-1:0] w_full;
   logic signed [WW-1:0] wc_in;
   logic                 sat_in;

   logic                 out_vld_ff;
   logic signed [WW-1:0] wa_ff, wb_ff, wc_ff;
   logic                 deg_ff, sat_ff;

   assign pt = '{req_ch.src_x, req_ch.src_y, req_ch.src_z};
   assign ca = '{req_ch.corner_a_x, req_ch.corner_a_y, req_ch.corner_a_z};
   assign cb = '{req_ch.corner_b_x, req_ch.corner_b_y, req_ch.corner_b_z};
   assign cc = '{req_ch.corner_c_x, req_ch.corner_c_y, req_ch.corner_c_z};

   tbw_dot #(.CW(CW)) u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .pt        (pt),
      .ca        (ca),
      .cb        (cb),
      .cc        (cc),
      .out_valid (dot_valid),
      .out_ready (dot_ready),
      .dot       (dot)
   );

   tbw_cross #(.CW(CW)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dot_valid),
      .in_ready  (dot_ready),
      .dot       (dot),
      .out_valid (crs_valid),
      .out_ready (crs_ready),
      .den       (den),
      .nu        (nu),
      .nv        (nv)
   );

   tbw_div #(.CW(CW), .FRAC(WEIGHT_FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (crs_valid),
      .in_ready  (crs_ready),
      .den       (den),
      .nu        (nu),
      .nv        (nv),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .weight    (weight),
      .sat       (div_sat),
      .deg       (div_deg)
   );

   assign div_ready = ~out_vld_ff | rsp_ch.ready;

   always_comb begin
      w_full = ONE - XW'(weight[0]) - XW'(weight[1]);
      sat_in = |div_sat;
      if (w_full > WMAX) begin
         wc_in  = WW'(WMAX);
         sat_in = 1'b1;
      end else if (w_full < WMIN) begin
         wc_in  = WW'(WMIN);
         sat_in = 1'b1;
      end else begin
         wc_in = WW'(w_full);
      end
      if (div_deg) begin
         wc_in  = '0;
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (div_ready) begin
         out_vld_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready) begin
         wa_ff  <= weight[0];
         wb_ff  <= weight[1];
         wc_ff  <= wc_in;
         deg_ff <= div_deg;
         sat_ff <= sat_in;
      end
   end

   assign rsp_ch.valid      = out_vld_ff;
   assign rsp_ch.weight_a   = wa_ff;
   assign rsp_ch.weight_b   = wb_ff;
   assign rsp_ch.weight_c   = wc_ff;
   assign rsp_ch.degenerate = deg_ff;
   assign rsp_ch.saturated  = sat_ff;

endmodule
`default_nettype wire

[dv/tbw_weights_checker.sv]
`timescale 1ns / 1ps
module tbw_weights_checker import tbw_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   tbw_req_if        req_ch,
   tbw_rsp_if        rsp_ch,
   output int        fail_count,
   output int        pending
);

   localparam int FRAC = 16;

   typedef logic signed [255:0] wide_type;

   typedef struct packed {
      logic signed [WEIGHT_WIDTH-1:0] weight_a;
      logic signed [WEIGHT_WIDTH-1:0] weight_b;
      logic signed [WEIGHT_WIDTH-1:0] weight_c;
      logic                           degenerate;
      logic                           saturated;
   } weights_type;

   weights_type expected_weights[$];

   function automatic wide_type clip_weight(input wide_type x, inout bit sat);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (WEIGHT_WIDTH - 1)) - 1;
      lo = -(wide_type'(1) <<< (WEIGHT_WIDTH - 1));
      if (x > hi) begin
         sat = 1;
         return hi;
      end
      if (x < lo) begin
         sat = 1;
         return lo;
      end
      return x;
   endfunction

   // Rounds n * 2^FRAC / d to nearest with ties away from zero, then clips.
   function automatic wide_type rounded_quotient(input wide_type n, input wide_type d,
                                                 inout bit sat);
      wide_type m;
      wide_type q;
      wide_type lim;
      bit       neg;
      neg = n < 0;
      m = neg ? -n : n;
      m = (m <<< (FRAC + 1)) + d;
      q = m / (d <<< 1);
      lim = neg ? (wide_type'(1) <<< (WEIGHT_WIDTH - 1))
                : (wide_type'(1) <<< (WEIGHT_WIDTH - 1)) - 1;
      if (q > lim) begin
         sat = 1;
         q = lim;
      end
      return neg ? -q : q;
   endfunction

   function automatic weights_type barycentric_weights(input wide_type crd[12]);
      wide_type    e0[3];
      wide_type    e1[3];
      wide_type    e2[3];
      wide_type    d00, d01, d11, d20, d21, den, u, v, w;
      bit          sat;
      weights_type r;
      for (int i = 0; i < 3; i++) begin
         e0[i] = crd[3 + i] - crd[9 + i];
         e1[i] = crd[6 + i] - crd[9 + i];
         e2[i] = crd[i] - crd[9 + i];
      end
      d00 = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
      d01 = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
      d11 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
      d20 = e2[0] * e0[0] + e2[1] * e0[1] + e2[2] * e0[2];
      d21 = e2[0] * e1[0] + e2[1] * e1[1] + e2[2] * e1[2];
      den = d00 * d11 - d01 * d01;
      r = '{default: '0};
      if (den <= 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      sat = 0;
      u = rounded_quotient(d11 * d20 - d01 * d21, den, sat);
      v = rounded_quotient(d00 * d21 - d01 * d20, den, sat);
      w = clip_weight((wide_type'(1) <<< FRAC) - u - v, sat);
      r.weight_a = u[WEIGHT_WIDTH-1:0];
      r.weight_b = v[WEIGHT_WIDTH-1:0];
      r.weight_c = w[WEIGHT_WIDTH-1:0];
      r.saturated = sat;
      return r;
   endfunction

   assign pending = expected_weights.size();

   always @(posedge clock) begin
      wide_type    crd[12];
      weights_type got;
      weights_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            crd = '{req_ch.src_x, req_ch.src_y, req_ch.src_z,
                    req_ch.corner_a_x, req_ch.corner_a_y, req_ch.corner_a_z,
                    req_ch.corner_b_x, req_ch.corner_b_y, req_ch.corner_b_z,
                    req_ch.corner_c_x, req_ch.corner_c_y, req_ch.corner_c_z};
            expected_weights.insert(expected_weights.size(), barycentric_weights(crd));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.weight_a, rsp_ch.weight_b, rsp_ch.weight_c,
                    rsp_ch.degenerate, rsp_ch.saturated};
            if (expected_weights.size() == 0) begin
               $error("response with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_weights.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  if (got.weight_a !== want.weight_a)
                     $error("weight_a expected %0d got %0d", want.weight_a, got.weight_a);
                  if (got.weight_b !== want.weight_b)
                     $error("weight_b expected %0d got %0d", want.weight_b, got.weight_b);
                  if (got.weight_c !== want.weight_c)
                     $error("weight_c expected %0d got %0d", want.weight_c, got.weight_c);
                  if (got.degenerate !== want.degenerate)
                     $error("degenerate expected %0b got %0b", want.degenerate,
                            got.degenerate);
                  if (got.saturated !== want.saturated)
                     $error("saturated expected %0b got %0b", want.saturated,
                            got.saturated);
               end
            end
         end
      end
   end

endmodule

[dv/tb_triangle_barycentric_weights_top.sv]
`timescale 1ns / 1ps
module tb_triangle_barycentric_weights_top;

   typedef logic signed [23:0] coord_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   idle_pct = 0;
   int   stall_pct = 0;

   tbw_req_if #(.COORD_WIDTH(24)) req_ch ();
   tbw_rsp_if                     rsp_ch ();

   triangle_barycentric_weights_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   tbw_weights_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_request(input coord_type c[12]);
      if ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      {req_ch.src_x, req_ch.src_y, req_ch.src_z,
       req_ch.corner_a_x, req_ch.corner_a_y, req_ch.corner_a_z,
       req_ch.corner_b_x, req_ch.corner_b_y, req_ch.corner_b_z,
       req_ch.corner_c_x, req_ch.corner_c_y, req_ch.corner_c_z}
         <= {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic coord_type near(input coord_type base, input int span);
      int x;
      x = int'(base) + $urandom_range(2 * span) - span;
      if (x > 8388607) x = 8388607;
      if (x < -8388608) x = -8388608;
      return coord_type'(x);
   endfunction

   // Most requests are compact triangles with the query point close by;
   // the rest are fully random, collinear, coincident or very thin triangles.
   task automatic send_random;
      coord_type c[12];
      coord_type d[3];
      int        kind;
      int        span;
      kind = $urandom_range(9);
      span = 1 << $urandom_range(4, 20);
      for (int i = 0; i < 3; i++) begin
         c[9 + i] = coord_type'($urandom_range(8388607)) - coord_type'(4194304);
         c[3 + i] = near(c[9 + i], span);
         c[6 + i] = near(c[9 + i], span);
         c[i] = near(c[9 + i], 2 * span);
         d[i] = coord_type'($urandom_range(2 * span) - span) >>> 1;
      end
      if (kind == 0) begin
         foreach (c[i]) c[i] = coord_type'($urandom);
      end else if (kind == 1) begin
         for (int i = 0; i < 3; i++) begin
            c[3 + i] = c[9 + i] + d[i];
            c[6 + i] = c[9 + i] + ($urandom_range(1) ? d[i] : -d[i] * 2);
         end
      end else if (kind == 2) begin
         for (int i = 0; i < 3; i++) c[6 + i] = c[3 + i] + $urandom_range(1);
      end
      send_request(c);
   endtask

   task automatic run_phase(input int idle, input int stall, input int count);
      idle_pct = idle;
      stall_pct = stall;
      repeat (count) send_random();
   endtask

   initial begin
      coord_type c[12];
      req_ch.valid = 1'b0;
      rsp_ch.ready = 1'b0;
      {req_ch.src_x, req_ch.src_y, req_ch.src_z,
       req_ch.corner_a_x, req_ch.corner_a_y, req_ch.corner_a_z,
       req_ch.corner_b_x, req_ch.corner_b_y, req_ch.corner_b_z,
       req_ch.corner_c_x, req_ch.corner_c_y, req_ch.corner_c_z} = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      c = '{default: 24'sd0};
      send_request(c);
      c = '{default: 24'sh7fffff};
      send_request(c);
      c = '{default: -24'sh800000};
      send_request(c);
      c = '{0, 0, 0, 24'sh1000, 0, 0, 0, 24'sh1000, 0, 0, 0, 0};
      send_request(c);
      c[0] = 24'sh1000;
      send_request(c);
      c[0] = 24'sh0555; c[1] = 24'sh0555;
      send_request(c);
      c[0] = 24'sh7fffff; c[1] = -24'sh800000;
      send_request(c);
      c = '{-24'sh800000, -24'sh800000, -24'sh800000, 24'sh7fffff, -24'sh800000,
            -24'sh800000, -24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff,
            24'sh7fffff, -24'sh800000};
      send_request(c);
      c = '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 1, 0, 0, 0, 1, 0, 0, 0, 0};
      send_request(c);
      c = '{0, 0, 0, 24'sh2000, 24'sh2000, 24'sh2000, 24'sh4000, 24'sh4000,
            24'sh4000, 0, 0, 0};
      send_request(c);
      c = '{24'sh12345, -24'sh3456, 24'sh777, 24'sh1000, 0, 0, 24'sh1000, 0, 0,
            0, 24'sh1000, 0};
      send_request(c);
      c = '{24'sh1, 0, 0, 24'sh3, 0, 0, 0, 24'sh3, 0, 0, 0, 0};
      send_request(c);

      run_phase(0, 0, 180);
      run_phase(61, 0, 180);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
      run_phase(0, 61, 180);
      run_phase(25, 25, 180);
      req_ch.valid <= 1'b0;
      @(posedge clock);

      wait (pending == 0);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
